// File: hdl/min_max_partition_search_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the min/max partition search block
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ---------------------------------------------------------------------------
`ifndef MIN_MAX_PARTITION_SEARCH_ASSERT_SVH
`define MIN_MAX_PARTITION_SEARCH_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MMPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MMPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mmps_pkg.sv
// ---------------------------------------------------------------------------
// mmps_pkg
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package mmps_pkg;

  localparam int DEF_MAX_STAGES  = 1024;
  localparam int DEF_LENGTH_BITS = 16;
  localparam int CAP_W           = 26;  // width of the reported capacity
  localparam int CFG_W           = 10;  // width of the allowed_refuels register

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store the input word and update sum and peak
    logic init;        // set the search bounds from peak and sum
    logic start_pass;  // latch the trial capacity and clear the pass state
    logic pass_step;   // advance the greedy pass by one stored stage
    logic decide;      // narrow the bounds from the segment count
    logic emit;        // move the result to the output and clear the sequence
  } mmps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cont;        // the search interval still holds more than one value
    logic pass_last;   // the pass has issued every stored stage
    logic out_free;    // the output register can take a word this cycle
  } mmps_sts_t;

endpackage

// File: hdl/min_max_partition_search.sv
// ---------------------------------------------------------------------------
// min_max_partition_search
// Smallest largest-segment sum over a loaded list of stage lengths.
// ---------------------------------------------------------------------------
// Usage: stage lengths arrive on the in_ channel, one word per accepted
// cycle, while the block is loading. The word with in_last_stage set closes
// the sequence; from then on in_stall stays high until the result moves to
// the output register. Words beyond MAX_STAGES are dropped and reported
// through out_overflow.
// The search binary-searches capacities from the largest stage up to the sum.
// Each trial runs a greedy pass that walks the stage memory, one entry per
// cycle through its single registered read port. The search runs at most
// T trials, T being ceil(log2(sum - peak + 1)).
// One result word leaves on the out_ channel per sequence. It sits in an
// output register; while out_stall holds it, the next sequence can already
// be loaded, and a new search finishing meanwhile waits for the slot.
// cfg_allowed_refuels is written whenever cfg_valid is high (cfg_ready is
// always high); write it only while the block is idle.
// Synchronous active-low reset clears the sequence and the register; the
// stage memory itself is not cleared and needs no sweep.
// ---------------------------------------------------------------------------
module min_max_partition_search
  import mmps_pkg::*;
#(
  parameter int MAX_STAGES  = DEF_MAX_STAGES,
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [LENGTH_BITS-1:0] in_stage_length,
  input  logic                   in_last_stage,
  // Result channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CAP_W-1:0]       out_min_capacity,
  output logic                   out_overflow,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_allowed_refuels
);

  mmps_cmd_t cmd;
  mmps_sts_t sts;

  // The register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  mmps_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_stage (in_last_stage),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  mmps_datapath #(
    .MAX_STAGES  (MAX_STAGES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_stage_length     (in_stage_length),
    .cfg_valid           (cfg_valid),
    .cfg_allowed_refuels (cfg_allowed_refuels),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_min_capacity    (out_min_capacity),
    .out_overflow        (out_overflow),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule

// File: hdl/mmps_ctrl.sv
// ---------------------------------------------------------------------------
// mmps_ctrl
// Sequencer for loading, bound search, greedy passes and result hand-off.
// ---------------------------------------------------------------------------
module mmps_ctrl
  import mmps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last_stage,
  output logic      in_stall,
  input  mmps_sts_t sts,
  output mmps_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_LOAD   = 6'b000001,
    ST_INIT   = 6'b000010,
    ST_CHECK  = 6'b000100,
    ST_PASS   = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_LOAD: begin
        cmd.load = in_valid;
        if (in_valid && in_last_stage) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.cont) begin
          cmd.start_pass = 1'b1;
          state_nxt      = ST_PASS;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_PASS: begin
        cmd.pass_step = 1'b1;
        if (sts.pass_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_LOAD);

`include "min_max_partition_search_assert.svh"

  `MMPS_ASSERT_NEXT(a_decide_to_check, state_r == ST_DECIDE, state_r == ST_CHECK, "decide must return to check")
  `MMPS_ASSERT_NEXT(a_pass_end, (state_r == ST_PASS) && sts.pass_last, state_r == ST_DECIDE, "pass end must lead to decide")
  `MMPS_ASSERT_NEXT(a_emit_reload, cmd.emit, (state_r == ST_LOAD) && !in_stall, "emit must reopen loading")

endmodule

// File: hdl/mmps_datapath.sv
// ---------------------------------------------------------------------------
// mmps_datapath
// Stage store, running sum and peak, search bounds, greedy pass and output.
// ---------------------------------------------------------------------------
module mmps_datapath
  import mmps_pkg::*;
#(
  parameter int MAX_STAGES  = DEF_MAX_STAGES,
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [LENGTH_BITS-1:0] in_stage_length,
  input  logic                   cfg_valid,
  input  logic [CFG_W-1:0]       cfg_allowed_refuels,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [CAP_W-1:0]       out_min_capacity,
  output logic                   out_overflow,
  input  mmps_cmd_t              cmd,
  output mmps_sts_t              sts
);

  localparam int CNT_W  = $clog2(MAX_STAGES + 1);
  localparam int ADDR_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int TOT_W  = LENGTH_BITS + CNT_W;
  localparam int SRCH_W = TOT_W + 1;
  localparam int SEG_W  = $clog2(MAX_STAGES + 2);
  localparam int CMP_W  = SEG_W + CFG_W + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STAGES);

  logic [LENGTH_BITS-1:0] mem [MAX_STAGES];

  logic [CFG_W-1:0]       refuels_r;
  logic [CNT_W-1:0]       count_r;
  logic [TOT_W-1:0]       total_r;
  logic [LENGTH_BITS-1:0] peak_r;
  logic                   ovf_r;
  logic [SRCH_W-1:0]      low_r;
  logic [SRCH_W-1:0]      high_r;
  logic [SRCH_W-1:0]      mid_r;
  logic [TOT_W-1:0]       acc_r;
  logic [SEG_W-1:0]       segs_r;
  logic [CNT_W-1:0]       pass_cnt_r;
  logic                   proc_vld_r;
  logic [LENGTH_BITS-1:0] rd_data_r;
  logic                   out_valid_r;
  logic [CAP_W-1:0]       out_cap_r;
  logic                   out_ovf_r;

  logic                   store_ok;
  logic                   rd_en;
  logic [SRCH_W:0]        mid_sum;
  logic [SRCH_W-1:0]      acc_sum;
  logic [CMP_W-1:0]       segs_ext;
  logic [CMP_W-1:0]       limit_ext;
  logic [SRCH_W+CAP_W-1:0] low_ext;

  assign store_ok  = (count_r != MAX_CNT);
  assign rd_en     = cmd.pass_step && (pass_cnt_r != count_r);
  assign mid_sum   = {1'b0, low_r} + {1'b0, high_r} - {{SRCH_W{1'b0}}, 1'b1};
  assign acc_sum   = {1'b0, acc_r} + {{(SRCH_W-LENGTH_BITS){1'b0}}, rd_data_r};
  assign segs_ext  = {{(CMP_W-SEG_W){1'b0}}, segs_r};
  assign limit_ext = {{(CMP_W-CFG_W){1'b0}}, refuels_r} + {{(CMP_W-1){1'b0}}, 1'b1};
  assign low_ext   = {{CAP_W{1'b0}}, low_r};

  assign sts.cont      = ({1'b0, low_r} + {{SRCH_W{1'b0}}, 1'b1}) < {1'b0, high_r};
  assign sts.pass_last = (pass_cnt_r == count_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Stage store: written while loading, read one entry per cycle in a pass.
  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      mem[count_r[ADDR_W-1:0]] <= in_stage_length;
    end
    if (rd_en) begin
      rd_data_r <= mem[pass_cnt_r[ADDR_W-1:0]];
    end
  end

  // Sequence state, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refuels_r   <= '0;
      count_r     <= '0;
      total_r     <= '0;
      peak_r      <= '0;
      ovf_r       <= 1'b0;
      low_r       <= '0;
      high_r      <= '0;
      proc_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        refuels_r <= cfg_allowed_refuels;
      end
      if (cmd.load) begin
        if (store_ok) begin
          count_r <= count_r + {{(CNT_W-1){1'b0}}, 1'b1};
          total_r <= total_r + {{CNT_W{1'b0}}, in_stage_length};
          if (in_stage_length > peak_r) begin
            peak_r <= in_stage_length;
          end
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.init) begin
        low_r  <= {{(SRCH_W-LENGTH_BITS){1'b0}}, peak_r};
        high_r <= {1'b0, total_r} + {{(SRCH_W-1){1'b0}}, 1'b1};
      end
      if (cmd.decide) begin
        if (segs_ext <= limit_ext) begin
          high_r <= mid_r + {{(SRCH_W-1){1'b0}}, 1'b1};
        end else begin
          low_r <= mid_r + {{(SRCH_W-1){1'b0}}, 1'b1};
        end
      end
      proc_vld_r <= rd_en;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        count_r     <= '0;
        total_r     <= '0;
        peak_r      <= '0;
        ovf_r       <= 1'b0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Greedy pass: one stored stage folded into the running segment per cycle; emit also latches the result word.
  always_ff @(posedge clk) begin
    if (cmd.start_pass) begin
      mid_r      <= mid_sum[SRCH_W:1];
      acc_r      <= '0;
      segs_r     <= {{(SEG_W-1){1'b0}}, 1'b1};
      pass_cnt_r <= '0;
    end else begin
      if (rd_en) begin
        pass_cnt_r <= pass_cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
      end
      if (proc_vld_r) begin
        if (acc_sum > mid_r) begin
          segs_r <= segs_r + {{(SEG_W-1){1'b0}}, 1'b1};
          acc_r  <= {{CNT_W{1'b0}}, rd_data_r};
        end else begin
          acc_r <= acc_sum[TOT_W-1:0];
        end
      end
    end
    if (cmd.emit) begin
      out_cap_r <= low_ext[CAP_W-1:0];
      out_ovf_r <= ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_min_capacity = out_cap_r;
  assign out_overflow     = out_ovf_r;

`include "min_max_partition_search_assert.svh"

  `MMPS_ASSERT_IMPLY(a_count_bound, 1'b1, count_r <= MAX_CNT, "stage count beyond store depth")
  `MMPS_ASSERT_IMPLY(a_bounds_order, cmd.emit || cmd.decide, low_r < high_r, "search bounds crossed")
  `MMPS_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid_r && (count_r == '0) && !ovf_r, "emit must show result and clear")

endmodule

// File: tb/min_max_partition_search_tb.sv
// ---------------------------------------------------------------------------
// min_max_partition_search_tb
// Self-checking bench for the min/max partition search block. Stage words are
// streamed in with random gaps and random result stalls; each result word is
// checked against a typed answer or an in-bench greedy binary search model.
// ---------------------------------------------------------------------------
module min_max_partition_search_tb
  import mmps_pkg::*;
();

  localparam int LEN_W         = DEF_LENGTH_BITS;
  localparam int MAX_STAGES    = DEF_MAX_STAGES;
  localparam int N_DIRECTED    = 25;
  localparam int RANDOM_WORDS  = 200;
  // The one calm stretch, free of gaps and stalls, covers these stage word counts.
  localparam int CALM_FROM     = 400;
  localparam int CALM_TO       = 600;
  // Cycles to wait after the last expected result before touching the register.
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  // The slowest legal run is one full-store search plus the loading, gaps, stalls
  // and short sequences; several times that still fits below this bound.
  localparam int CYCLE_LIMIT   = 2000000;

  // One result word: the capacity and the overflow flag.
  typedef struct packed {
    logic [CAP_W-1:0] cap;
    logic             ovf;
  } capacity_word_t;

  // One row of the directed table. When cfg_wr is set the register is written
  // before the row's stage word goes out. When typed is set the row closes a
  // sequence whose answer is obvious and is given here directly.
  typedef struct packed {
    bit               cfg_wr;
    logic [CFG_W-1:0] cfg;
    logic [LEN_W-1:0] len;
    logic             last;
    bit               typed;
    logic [CAP_W-1:0] cap;
    logic             ovf;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [LEN_W-1:0]   in_stage_length = '0;
  logic               in_last_stage = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CAP_W-1:0]   out_min_capacity;
  logic               out_overflow;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_allowed_refuels = '0;

  // Shadow state of the block, kept in step with accepted words.
  logic [LEN_W-1:0]   stage_mem [MAX_STAGES];
  int unsigned        held_stages;
  logic [CAP_W-1:0]   stage_total;
  logic [LEN_W-1:0]   stage_peak;
  bit                 store_overflowed;
  logic [CFG_W-1:0]   refuels;

  capacity_word_t     capacity_q [$];
  capacity_word_t     oldest;

  bit                 calm = 1'b0;
  int unsigned        cycle_count = 0;
  int unsigned        stages_sent = 0;
  int unsigned        results_seen = 0;
  int unsigned        settings_used = 0;
  int unsigned        mismatches = 0;

  // Sequences of the directed part. Refuel count 0 forces one segment, so the
  // answer is the sum; refuel count 1023 allows one segment per stage, so the
  // answer is the largest stage.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{1'b1, 10'd0,    16'd0,     1'b1, 1'b1, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd65535, 1'b1, 1'b1, 26'd65535,  1'b0},
    '{1'b0, 10'd0,    16'd65535, 1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd65535, 1'b1, 1'b1, 26'd131070, 1'b0},
    '{1'b0, 10'd0,    16'd1,     1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd2,     1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd3,     1'b1, 1'b1, 26'd6,      1'b0},
    '{1'b1, 10'd1023, 16'd5,     1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd9,     1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd2,     1'b1, 1'b1, 26'd9,      1'b0},
    '{1'b0, 10'd0,    16'd0,     1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd0,     1'b1, 1'b1, 26'd0,      1'b0},
    '{1'b1, 10'd1,    16'd7,     1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd3,     1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd4,     1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd6,     1'b1, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd65535, 1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd0,     1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd65535, 1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd1,     1'b1, 1'b0, 26'd0,      1'b0},
    '{1'b1, 10'd2,    16'd10,    1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd20,    1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd30,    1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd40,    1'b0, 1'b0, 26'd0,      1'b0},
    '{1'b0, 10'd0,    16'd50,    1'b1, 1'b0, 26'd0,      1'b0}
  };

  min_max_partition_search u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_stage_length     (in_stage_length),
    .in_last_stage       (in_last_stage),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_min_capacity    (out_min_capacity),
    .out_overflow        (out_overflow),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_allowed_refuels (cfg_allowed_refuels)
  );

  always #4 clk = ~clk;

  // Hard stop in case the block hangs or never drains.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Number of segments the held stages split into when no segment may sum to
  // more than cap. A new segment starts at the stage that would overshoot.
  function automatic int unsigned count_legs(input longint cap);
    longint      acc;
    int unsigned legs;
    acc  = 0;
    legs = 1;
    for (int unsigned i = 0; i < held_stages; i++) begin
      acc += stage_mem[i];
      if (acc > cap) begin
        legs++;
        acc = stage_mem[i];
      end
    end
    return legs;
  endfunction

  // Takes one accepted stage word into the shadow state. On the closing word
  // it runs the capacity search and hands back the result word.
  task automatic absorb_stage(input logic [LEN_W-1:0] len, input logic last,
                              output bit done, output capacity_word_t word);
    longint      lo;
    longint      hi;
    longint      mid;
    int unsigned legs_allowed;
    done = 1'b0;
    word = '0;
    // A full store drops the word but remembers that it happened.
    if (held_stages < MAX_STAGES) begin
      stage_mem[held_stages] = len;
      held_stages++;
      stage_total += len;
      if (len > stage_peak) begin
        stage_peak = len;
      end
    end else begin
      store_overflowed = 1'b1;
    end
    if (last) begin
      // Search the half-open interval [peak, sum + 1) for the first capacity
      // that fits within the allowed number of segments.
      legs_allowed = refuels + 1;
      lo = longint'(stage_peak);
      hi = longint'(stage_total) + 1;
      while (lo + 1 < hi) begin
        mid = (lo + hi - 1) / 2;
        if (count_legs(mid) <= legs_allowed) begin
          hi = mid + 1;
        end else begin
          lo = mid + 1;
        end
      end
      word.cap         = lo[CAP_W-1:0];
      word.ovf         = store_overflowed;
      done             = 1'b1;
      held_stages      = 0;
      stage_total      = '0;
      stage_peak       = '0;
      store_overflowed = 1'b0;
    end
  endtask

  function automatic bit want_gap();
    return !calm && ($urandom_range(99) < 17);
  endfunction

  // Sends one stage word. It starts at a falling edge, may idle first, and
  // returns at the rising edge where the word was taken.
  task automatic send_stage(input logic [LEN_W-1:0] len, input logic last,
                            input bit typed, input capacity_word_t typed_word);
    int unsigned    gap;
    bit             done;
    capacity_word_t word;
    calm = (stages_sent >= CALM_FROM) && (stages_sent < CALM_TO);
    // Each cycle idles with the same chance, so gaps are geometric.
    gap  = 0;
    while (want_gap()) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_stage_length <= len;
    in_last_stage   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    stages_sent++;
    absorb_stage(len, last, done, word);
    if (done) begin
      capacity_q.push_back(typed ? typed_word : word);
    end
  endtask

  // Stops the input side and waits until every expected result has arrived,
  // so the block is idle before the register changes.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (capacity_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_refuels(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid           <= 1'b1;
    cfg_allowed_refuels <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    refuels = value;
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stage values by flavor: full range, tiny, extremes only, or 0 to 255.
  function automatic logic [LEN_W-1:0] pick_length(input int unsigned flavor);
    case (flavor)
      0:       return LEN_W'($urandom_range(0, 65535));
      1:       return LEN_W'($urandom_range(0, 15));
      2:       return $urandom_range(1) ? '1 : '0;
      default: return LEN_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly short sequences keep the search cheap; a few go longer.
  function automatic int unsigned pick_run_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      return $urandom_range(1, 8);
    end else if (r < 95) begin
      return $urandom_range(9, 32);
    end
    return $urandom_range(33, 64);
  endfunction

  function automatic logic [CFG_W-1:0] pick_setting(input int unsigned phase);
    case (phase % 5)
      0:       return '1;
      1:       return '0;
      2:       return CFG_W'($urandom_range(1, 3));
      3:       return CFG_W'($urandom_range(0, 1023));
      default: return CFG_W'($urandom_range(4, 40));
    endcase
  endfunction

  // One whole sequence of random stage words, the last one closing it.
  task automatic send_random_run(input int unsigned count, input int unsigned flavor);
    for (int unsigned i = 0; i < count; i++) begin
      send_stage(pick_length(flavor), i == count - 1, 1'b0, '0);
    end
  endtask

  // The receiver stalls at random, except during the calm stretch.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 17);
  end

  // Every accepted result word is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (capacity_q.size() == 0) begin
        $error("unexpected result word: min_capacity %0d overflow %0b",
               out_min_capacity, out_overflow);
        mismatches++;
      end else begin
        oldest = capacity_q.pop_front();
        if (out_min_capacity !== oldest.cap) begin
          $error("min_capacity: expected %0d, actual %0d", oldest.cap, out_min_capacity);
          mismatches++;
        end
        if (out_overflow !== oldest.ovf) begin
          $error("overflow: expected %0b, actual %0b", oldest.ovf, out_overflow);
          mismatches++;
        end
        results_seen++;
      end
    end
  end

  initial begin
    int unsigned    phase;
    int unsigned    runs;
    capacity_word_t typed_word;

    held_stages      = 0;
    stage_total      = '0;
    stage_peak       = '0;
    store_overflowed = 1'b0;
    refuels          = '0;
    phase            = 0;
    runs             = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table first.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_wr) begin
        settle();
        write_refuels(directed_rows[i].cfg);
      end
      typed_word.cap = directed_rows[i].cap;
      typed_word.ovf = directed_rows[i].ovf;
      send_stage(directed_rows[i].len, directed_rows[i].last,
                 directed_rows[i].typed, typed_word);
    end

    // Random sequences, moving to a new refuel setting every 4 sequences.
    while (stages_sent < N_DIRECTED + RANDOM_WORDS) begin
      if (runs % 4 == 0) begin
        settle();
        write_refuels(pick_setting(phase));
        phase++;
      end
      send_random_run(pick_run_length(), $urandom_range(0, 3));
      runs++;
    end

    // A store filled to the brim and then overrun, closed by a word that
    // gets dropped.
    settle();
    write_refuels(CFG_W'($urandom_range(0, 31)));
    send_random_run(MAX_STAGES + $urandom_range(1, 6), 3);

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d stage words under %0d refuel settings; %0d results checked.",
             stages_sent, settings_used, results_seen);
    $display("Runs covered a store overflow and %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
